// ===== rtl/core/fcstm_pkg.sv =====
// shared types, widths and constants of the square tone mixer
package fcstm_pkg;

    localparam int NUM_CHANNELS_DEF    = 4;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_CHANNELS        = 4;

    localparam int KIND_W   = 1;
    localparam int OFFSET_W = 4;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 20;
    localparam int DIV_W    = 8;
    localparam int HP_W     = 28;
    localparam int AMP_W    = 13;
    localparam int MIX_W    = 18;
    localparam int CH_IDX_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 1'b1;

    localparam logic [OFFSET_W-1:0] CLOCK_SELECT_OFFSET = 4'd8;

    // register index as seen at paddr[2]
    localparam logic REG_SLOW_STEP = 1'b0;
    localparam logic REG_FAST_STEP = 1'b1;

    localparam logic [STEP_W-1:0] SLOW_STEP_RESET = 20'd22607;
    localparam logic [STEP_W-1:0] FAST_STEP_RESET = 20'd807;

    localparam int LOW_PAIR_FAST_BIT  = 4;
    localparam int HIGH_PAIR_FAST_BIT = 6;
    localparam int MUTE_BIT           = 4;
    localparam int VOLUME_W           = 4;
    localparam int VOLUME_SHIFT       = 9;

    localparam logic signed [MIX_W-1:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [MIX_W-1:0] SAMPLE_MIN = -18'sd32768;

endpackage

// ===== rtl/core/fcstm_in_if.sv =====
// input item channel: register write or sample tick
interface fcstm_in_if import fcstm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] reg_offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output kind, output reg_offset, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_offset, input write_data,
                    output ready);
endinterface

// ===== rtl/core/fcstm_out_if.sv =====
// result channel: one mixed sample per tick
interface fcstm_out_if import fcstm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/four_channel_square_tone_mixer.sv =====
// four-channel square tone mixer: top level with channel lanes and sample mixer
// path: a tick beat passes the input register, then the sample register
// throughput: one beat per cycle (write or tick) unless a tick waits on a full
//   sample register, set by the single-pass channel update between the registers
// reset: synchronous active-low i_rst_n zeroes all channel state and the clock
//   select, loads the step registers with their defaults; no clearing pass
module four_channel_square_tone_mixer import fcstm_pkg::*; #(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcstm_in_if.sink              i_item,
    fcstm_out_if.source           o_sample,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // one period step of 1.0 in phase units
    localparam logic [HP_W:0] PHASE_ONE = (HP_W+1)'(1) << PHASE_FRAC_BITS;

    // ---------------------------------------------------------------
    // configuration port: steps in half-period units per divider count
    // ---------------------------------------------------------------
    logic [STEP_W-1:0] r_slow_step;
    logic [STEP_W-1:0] r_fast_step;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_step <= SLOW_STEP_RESET;
            r_fast_step <= FAST_STEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SLOW_STEP) begin
                r_slow_step <= pwdata[STEP_W-1:0];
            end else begin
                r_fast_step <= pwdata[STEP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FAST_STEP) begin
            prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_fast_step};
        end else begin
            prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_slow_step};
        end
    end

    // ---------------------------------------------------------------
    // input register; a write beat never waits on the output side,
    // a tick beat moves on once the sample register is free or draining
    // ---------------------------------------------------------------
    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [OFFSET_W-1:0] r_in_off;
    logic [DATA_W-1:0]   r_in_data;
    logic                r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic out_free;
    logic proc_fire;
    logic wr_fire;
    logic tick_fire;
    logic cs_wr;

    assign out_free     = !r_out_valid || o_sample.ready;
    assign proc_fire    = r_in_valid && ((r_in_kind == KIND_WRITE) || out_free);
    assign wr_fire      = proc_fire && (r_in_kind == KIND_WRITE);
    assign tick_fire    = proc_fire && (r_in_kind == KIND_TICK);
    assign cs_wr        = wr_fire && (r_in_off == CLOCK_SELECT_OFFSET);
    assign i_item.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind <= i_item.kind;
            r_in_off  <= i_item.reg_offset;
            r_in_data <= i_item.write_data;
        end
    end

    // clock select: the new byte takes effect for the recompute in the same beat
    logic [DATA_W-1:0] r_clock_select;
    logic [DATA_W-1:0] cs_eff;

    assign cs_eff = cs_wr ? r_in_data : r_clock_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_select <= '0;
        end else if (cs_wr) begin
            r_clock_select <= r_in_data;
        end
    end

    // ---------------------------------------------------------------
    // channel lanes: divider, half period, phase, sign, amplitude
    // ---------------------------------------------------------------
    logic             lane_sign_next [NUM_CHANNELS];
    logic             lane_run       [NUM_CHANNELS];
    logic [AMP_W-1:0] lane_amp       [NUM_CHANNELS];

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        localparam int FAST_BIT = (g >= 2) ? HIGH_PAIR_FAST_BIT : LOW_PAIR_FAST_BIT;

        logic [DIV_W-1:0]  r_div;
        logic [HP_W-1:0]   r_hp;
        logic [HP_W-1:0]   r_phase;
        logic              r_sign;
        logic [AMP_W-1:0]  r_amp;

        logic              hit;
        logic              div_wr;
        logic              ctl_wr;
        logic [DIV_W-1:0]  div_eff;
        logic [STEP_W-1:0] step;
        logic [DIV_W+STEP_W:0] prod;
        logic [HP_W-1:0]   hp_new;
        logic [VOLUME_W-1:0] vol;
        logic [HP_W:0]     ph_sum;
        logic              wrap;

        assign hit    = wr_fire && !r_in_off[OFFSET_W-1]
                     && (r_in_off[CH_IDX_W:1] == CH_IDX_W'(g));
        assign div_wr = hit && !r_in_off[0];
        assign ctl_wr = hit && r_in_off[0];

        // half period = (divider + 1) * step, below 1.0 means off
        assign div_eff = div_wr ? r_in_data : r_div;
        assign step    = cs_eff[FAST_BIT] ? r_fast_step : r_slow_step;
        assign prod    = ({1'b0, div_eff} + (DIV_W+1)'(1)) * step;
        assign hp_new  = (prod < (DIV_W+STEP_W+1)'(PHASE_ONE)) ? '0 : prod[HP_W-1:0];

        assign vol = r_in_data[VOLUME_W-1:0];

        // one subtraction per tick, even if the phase is far past the half period
        assign ph_sum = {1'b0, r_phase} + PHASE_ONE;
        assign wrap   = (ph_sum >= {1'b0, r_hp});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div   <= '0;
                r_hp    <= '0;
                r_phase <= '0;
                r_sign  <= 1'b0;
                r_amp   <= '0;
            end else begin
                if (div_wr) begin
                    r_div <= r_in_data;
                end
                if (div_wr || cs_wr) begin
                    r_hp <= hp_new;
                end else if (ctl_wr && (vol == '0)) begin
                    r_hp <= '0;
                end
                if (ctl_wr) begin
                    if (r_in_data[MUTE_BIT]) begin
                        r_amp <= '0;
                    end else begin
                        r_amp <= {vol, {VOLUME_SHIFT{1'b0}}};
                    end
                end
                if (tick_fire && (r_hp != '0)) begin
                    if (wrap) begin
                        r_phase <= HP_W'(ph_sum - {1'b0, r_hp});
                        r_sign  <= !r_sign;
                    end else begin
                        r_phase <= ph_sum[HP_W-1:0];
                    end
                end
            end
        end

        assign lane_run[g]       = (r_hp != '0);
        assign lane_sign_next[g] = wrap ? !r_sign : r_sign;
        assign lane_amp[g]       = r_amp;
    end

    // ---------------------------------------------------------------
    // mixer: signed sum of running channels, clamped to 16 bits
    // ---------------------------------------------------------------
    logic signed [MIX_W-1:0]    mix;
    logic signed [SAMPLE_W-1:0] mix_sat;

    always_comb begin
        mix = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (lane_run[c]) begin
                if (lane_sign_next[c]) begin
                    mix = mix + $signed({{(MIX_W-AMP_W){1'b0}}, lane_amp[c]});
                end else begin
                    mix = mix - $signed({{(MIX_W-AMP_W){1'b0}}, lane_amp[c]});
                end
            end
        end
    end

    always_comb begin
        priority if (mix > SAMPLE_MAX) begin
            mix_sat = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (mix < SAMPLE_MIN) begin
            mix_sat = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            mix_sat = mix[SAMPLE_W-1:0];
        end
    end

    // sample register, holds its beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_sample.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_out_sample <= mix_sat;
        end
    end

    assign o_sample.valid  = r_out_valid;
    assign o_sample.sample = r_out_sample;

endmodule

// ===== sim/four_channel_square_tone_mixer_tb.sv =====
// self-checking testbench for the four-channel square tone mixer
`timescale 1ns / 1ps

module four_channel_square_tone_mixer_tb;
    import fcstm_pkg::*;

    localparam int ITEMS_PER_PHASE = 240;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_PRINTED     = 100;

    // tracks the channel state and the samples still owed by the block
    class tone_mix_tracker;
        logic [STEP_W-1:0]          slow_step;
        logic [STEP_W-1:0]          fast_step;
        logic [DATA_W-1:0]          clk_sel;
        logic [DIV_W-1:0]           div_byte  [MAX_CHANNELS];
        logic [HP_W-1:0]            half_per  [MAX_CHANNELS];
        logic [HP_W-1:0]            phase     [MAX_CHANNELS];
        logic                       high_half [MAX_CHANNELS];
        logic [AMP_W-1:0]           amp       [MAX_CHANNELS];
        logic signed [SAMPLE_W-1:0] pending_samples[$];

        function new();
            slow_step = SLOW_STEP_RESET;
            fast_step = FAST_STEP_RESET;
            clk_sel   = '0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                div_byte[c]  = '0;
                half_per[c]  = '0;
                phase[c]     = '0;
                high_half[c] = 1'b0;
                amp[c]       = '0;
            end
        endfunction

        function void set_step(logic reg_idx, logic [STEP_W-1:0] value);
            if (reg_idx == REG_SLOW_STEP)
                slow_step = value;
            else
                fast_step = value;
        endfunction

        // half period = (divider + 1) * step, silenced below one sample
        function void load_divider(int ch, logic [DIV_W-1:0] d);
            longint unsigned prod;
            logic            fast;
            fast = (ch >= 2) ? clk_sel[HIGH_PAIR_FAST_BIT] : clk_sel[LOW_PAIR_FAST_BIT];
            prod = d;
            prod = (prod + 1) * (fast ? fast_step : slow_step);
            div_byte[ch] = d;
            if (prod < (64'd1 << PHASE_FRAC_BITS_DEF))
                half_per[ch] = '0;
            else
                half_per[ch] = prod[HP_W-1:0];
        endfunction

        function void set_volume(int ch, logic [DATA_W-1:0] c);
            logic [VOLUME_W-1:0] vol;
            vol = c[VOLUME_W-1:0];
            amp[ch] = c[MUTE_BIT] ? '0 : {vol, {VOLUME_SHIFT{1'b0}}};
            // zero volume also stops the channel
            if (vol == '0)
                half_per[ch] = '0;
        endfunction

        function void note_beat(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] off,
                                logic [DATA_W-1:0] data);
            int          mix;
            int unsigned ph;
            if (kind == KIND_WRITE) begin
                if (off == CLOCK_SELECT_OFFSET) begin
                    clk_sel = data;
                    for (int c = 0; c < NUM_CHANNELS_DEF; c++)
                        load_divider(c, div_byte[c]);
                end else if (off < CLOCK_SELECT_OFFSET) begin
                    if (off[0] == 1'b0)
                        load_divider(int'(off[OFFSET_W-1:1]), data);
                    else
                        set_volume(int'(off[OFFSET_W-1:1]), data);
                end
                return;
            end
            mix = 0;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
                if (half_per[c] == '0)
                    continue;
                // wide sum: phase plus one sample may pass 28 bits
                ph = phase[c] + (32'd1 << PHASE_FRAC_BITS_DEF);
                if (ph >= half_per[c]) begin
                    ph = ph - half_per[c];
                    high_half[c] = ~high_half[c];
                end
                phase[c] = ph[HP_W-1:0];
                mix = high_half[c] ? mix + int'(amp[c]) : mix - int'(amp[c]);
            end
            if (mix > SAMPLE_MAX)
                mix = SAMPLE_MAX;
            if (mix < SAMPLE_MIN)
                mix = SAMPLE_MIN;
            pending_samples.push_back(SAMPLE_W'(mix));
        endfunction

        // empty string when the sample matches the oldest expected one
        function string check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (pending_samples.size() == 0)
                return $sformatf("sample %0d arrived with none expected", got);
            want = pending_samples.pop_front();
            if (got !== want)
                return $sformatf("sample mismatch: got %0d want %0d", got, want);
            return "";
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fcstm_in_if  item_bus ();
    fcstm_out_if sample_bus ();

    tone_mix_tracker tracker = new();

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit long_hold_req  = 1'b0;

    four_channel_square_tone_mixer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_sample (sample_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // offers one beat, with random idle cycles ahead of it, until accepted
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [OFFSET_W-1:0] off,
                             input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.kind       <= kind;
        item_bus.reg_offset <= off;
        item_bus.write_data <= data;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1)
            @(posedge i_clk);
        tracker.note_beat(kind, off, data);
    endtask

    // drops valid, then waits until every owed sample has come back
    task automatic wait_for_samples();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_samples.size() != 0)
            @(posedge i_clk);
        // writes give no sample, so let any still in flight land
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(input logic reg_idx, input logic [STEP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_step(reg_idx, value);
    endtask

    // mostly ticks and meaningful writes, some ignored offsets and raw noise
    task automatic send_random_item(output bit counted);
        int                  roll;
        int                  ch;
        logic [DATA_W-1:0]   data;
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] off;
        roll    = $urandom_range(99);
        ch      = $urandom_range(NUM_CHANNELS_DEF - 1);
        data    = DATA_W'($urandom_range(255));
        counted = 1'b1;
        if (roll < 50) begin
            send_beat(KIND_TICK, OFFSET_W'($urandom_range(15)), data);
        end else if (roll < 68) begin
            // short dividers give fast tones at the slow step
            if ($urandom_range(1) == 1)
                data = DATA_W'($urandom_range(40));
            send_beat(KIND_WRITE, OFFSET_W'(2 * ch), data);
        end else if (roll < 86) begin
            if ($urandom_range(99) < 75) begin
                data[MUTE_BIT] = 1'b0;
                if (data[VOLUME_W-1:0] == '0)
                    data[VOLUME_W-1:0] = VOLUME_W'($urandom_range(15, 1));
            end
            send_beat(KIND_WRITE, OFFSET_W'(2 * ch + 1), data);
        end else if (roll < 92) begin
            send_beat(KIND_WRITE, CLOCK_SELECT_OFFSET, data);
        end else if (roll < 96) begin
            counted = 1'b0;
            send_beat(KIND_WRITE, OFFSET_W'($urandom_range(15, 9)), data);
        end else begin
            kind    = KIND_W'($urandom_range(1));
            off     = OFFSET_W'($urandom_range(15));
            counted = !(kind == KIND_WRITE && off > CLOCK_SELECT_OFFSET);
            send_beat(kind, off, data);
        end
    endtask

    // result side: checks every sample beat, stalls at random or for a long hold
    initial begin
        int    hold_left;
        string msg;
        hold_left = 0;
        sample_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) begin
                msg = tracker.check_sample(sample_bus.sample);
                if (msg != "")
                    report_mismatch(msg);
            end
            if (i_rst_n !== 1'b1) begin
                sample_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                sample_bus.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                sample_bus.ready <= 1'b0;
            end else begin
                sample_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int                total;
        int                counted_in_phase;
        bit                counted;
        logic [STEP_W-1:0] slow_val;
        logic [STEP_W-1:0] fast_val;

        total = 0;
        i_rst_n             <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.kind       <= KIND_WRITE;
        item_bus.reg_offset <= '0;
        item_bus.write_data <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset steps
        send_idle_pct = 38;
        recv_idle_pct = 67;
        send_beat(KIND_WRITE, 4'd1, 8'h0F);          // ch0 full volume
        send_beat(KIND_WRITE, 4'd0, 8'hFF);          // ch0 longest divider
        send_beat(KIND_WRITE, 4'd3, 8'h1F);          // ch1 muted
        send_beat(KIND_WRITE, 4'd2, 8'h00);          // ch1 below one sample, silent
        send_beat(KIND_WRITE, 4'd5, 8'h08);
        send_beat(KIND_WRITE, 4'd4, 8'h80);
        send_beat(KIND_WRITE, 4'd7, 8'h0F);
        send_beat(KIND_WRITE, 4'd6, 8'h51);
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_WRITE, CLOCK_SELECT_OFFSET, 8'h50);  // both pairs fast
        send_beat(KIND_TICK, 4'd15, 8'hFF);
        send_beat(KIND_TICK, 4'd8, 8'h00);
        send_beat(KIND_TICK, 4'd7, 8'hFF);
        send_beat(KIND_WRITE, 4'd9, 8'hAA);          // unused offsets do nothing
        send_beat(KIND_WRITE, 4'd15, 8'hFF);
        send_beat(KIND_WRITE, CLOCK_SELECT_OFFSET, 8'h00);  // back to slow
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_WRITE, 4'd7, 8'h00);          // zero volume stops ch3
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_WRITE, 4'd7, 8'h0C);          // volume alone does not restart
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_WRITE, 4'd0, 8'h02);          // ch0 half period shrinks under phase
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_TICK, 4'd0, 8'h00);
        send_beat(KIND_TICK, 4'd0, 8'h00);
        wait_for_samples();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    slow_val = 20'hFFFFF;
                    fast_val = 20'd1;
                end
                1: begin
                    slow_val = 20'd1;
                    fast_val = 20'hFFFFF;
                end
                2: begin
                    // zero step silences, a one-sample step flips every tick at divider 0
                    slow_val = 20'd0;
                    fast_val = 20'd65536;
                end
                3: begin
                    slow_val = STEP_W'($urandom_range(200000, 1));
                    fast_val = STEP_W'($urandom_range(1048575, 1));
                end
                default: begin
                    slow_val = SLOW_STEP_RESET;
                    fast_val = FAST_STEP_RESET;
                end
            endcase
            write_step(REG_SLOW_STEP, slow_val);
            write_step(REG_FAST_STEP, fast_val);

            counted_in_phase = 0;
            while (counted_in_phase < ITEMS_PER_PHASE) begin
                // idle mix: sender-light first, then receiver-light, then none
                if (total < 400) begin
                    send_idle_pct = 38;
                    recv_idle_pct = 67;
                end else if (total < 800) begin
                    send_idle_pct = 67;
                    recv_idle_pct = 38;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_random_item(counted);
                if (counted) begin
                    counted_in_phase++;
                    total++;
                    // long result stall while beats keep coming, to back up the input
                    if (total == 150 || total == 1000)
                        long_hold_req = 1'b1;
                    if (total == 600)
                        wait_for_samples();
                end
            end
            wait_for_samples();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== four_channel_square_tone_mixer.f =====
rtl/core/fcstm_pkg.sv
rtl/core/fcstm_in_if.sv
rtl/core/fcstm_out_if.sv
rtl/core/four_channel_square_tone_mixer.sv
sim/four_channel_square_tone_mixer_tb.sv
